@@ hw/rtl/rotenc_pkg.sv @@
`timescale 1ns / 1ps

package rotenc_pkg;

  // Timestamp width; differences wrap modulo 2^TIME_BITS
  localparam int TIME_BITS        = 32;
  // Sub-steps that make one detent
  localparam int STEPS_PER_DETENT = 4;
  // Sub-step counter width, signed, holds +/- STEPS_PER_DETENT
  localparam int STEP_W           = 4;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_PRESS = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = CFG_W'(20);
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = CFG_W'(600);
  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RESET = CFG_W'(350);

  localparam logic signed [STEP_W-1:0] STEP_LIMIT = STEP_W'(STEPS_PER_DETENT);

  // Quadrature transition table, index = {prev_ab, cur_ab}; 01 = +1, 11 = -1
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic [2:0] {
    EV_CW     = 3'd0,
    EV_CCW    = 3'd1,
    EV_PRESS  = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  // One result from a decoder unit
  typedef struct packed {
    logic   valid;
    event_t code;
  } result_t;

  // One entry of the output queue
  typedef struct packed {
    event_t code;
    logic   last;
  } oq_entry_t;

  // Output queue sizing (power of two depth)
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

endpackage

@@ hw/rtl/rotenc_quad.sv @@
`timescale 1ns / 1ps

module rotenc_quad (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               chan_a,
  input  logic               chan_b,
  output rotenc_pkg::result_t rot
);
  import rotenc_pkg::*;

  logic [1:0]               prev_ab;
  logic [1:0]               cur_ab;
  logic signed [STEP_W-1:0] sub_step;
  logic signed [STEP_W-1:0] sub_sum;
  logic signed [1:0]        delta;
  logic                     changed;
  logic                     at_cw;
  logic                     at_ccw;

  // Table lookup and accumulate
  assign cur_ab  = {chan_a, chan_b};
  assign changed = (cur_ab != prev_ab);
  assign delta   = QUAD_TABLE[{prev_ab, cur_ab}];
  assign sub_sum = sub_step + {{(STEP_W-2){delta[1]}}, delta};
  assign at_cw   = (sub_sum >= STEP_LIMIT);
  assign at_ccw  = (sub_sum <= -STEP_LIMIT);

  always_comb begin
    rot.valid = changed && (at_cw || at_ccw);
    rot.code  = at_cw ? EV_CW : EV_CCW;
  end

  // Pair and sub-step state; count clears on a detent
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab  <= 2'b11;
      sub_step <= '0;
    end else if (step && changed) begin
      prev_ab  <= cur_ab;
      sub_step <= rot.valid ? '0 : sub_sum;
    end
  end

endmodule

@@ hw/rtl/rotenc_switch.sv @@
`timescale 1ns / 1ps

module rotenc_switch (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             switch_down,
  input  rotenc_pkg::stamp_t               now,
  input  logic                             wr_en,
  input  logic [rotenc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rotenc_pkg::CFG_W-1:0]     wr_data,
  output rotenc_pkg::result_t              sw
);
  import rotenc_pkg::*;

  logic [CFG_W-1:0] debounce_time;
  logic [CFG_W-1:0] hold_time;
  logic [CFG_W-1:0] window_time;

  logic   held, held_next;
  logic   long_fired, long_fired_next;
  logic   click_pending, click_pending_next;
  stamp_t edge_time, edge_time_next;
  stamp_t press_start_time, press_start_time_next;
  stamp_t release_time, release_time_next;

  stamp_t el_edge;
  stamp_t el_press;
  stamp_t el_rel;
  logic   sw_edge;
  logic   bounce;
  logic   in_window;

  // Wrapping time differences
  assign el_edge   = now - edge_time;
  assign el_press  = now - press_start_time;
  assign el_rel    = now - release_time;
  assign sw_edge   = (switch_down != held);
  assign bounce    = (el_edge < stamp_t'(debounce_time));
  assign in_window = (el_rel < stamp_t'(window_time));

  // Gesture classification
  always_comb begin
    held_next             = held;
    long_fired_next       = long_fired;
    click_pending_next    = click_pending;
    edge_time_next        = edge_time;
    press_start_time_next = press_start_time;
    release_time_next     = release_time;
    sw                    = '0;
    if (sw_edge) begin
      if (!bounce) begin
        edge_time_next = now;
        if (switch_down) begin
          held_next             = 1'b1;
          press_start_time_next = now;
          long_fired_next       = 1'b0;
        end else begin
          held_next = 1'b0;
          if (long_fired) begin
            click_pending_next = 1'b0;
          end else if (click_pending && in_window) begin
            sw.valid           = 1'b1;
            sw.code            = EV_DOUBLE;
            click_pending_next = 1'b0;
          end else begin
            click_pending_next = 1'b1;
            release_time_next  = now;
          end
        end
      end
    end else begin
      // held and not held exclude each other: at most one result
      if (held && !long_fired && (el_press >= stamp_t'(hold_time))) begin
        long_fired_next = 1'b1;
        sw.valid        = 1'b1;
        sw.code         = EV_LONG;
      end
      if (click_pending && !held && !in_window) begin
        sw.valid           = 1'b1;
        sw.code            = EV_PRESS;
        click_pending_next = 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      hold_time     <= LONG_PRESS_RESET;
      window_time   <= DOUBLE_PRESS_RESET;
    end else if (wr_en) begin
      if (wr_index == CFG_DEBOUNCE)     debounce_time <= wr_data;
      if (wr_index == CFG_LONG_PRESS)   hold_time     <= wr_data;
      if (wr_index == CFG_DOUBLE_PRESS) window_time   <= wr_data;
    end
  end

  // Switch state
  always_ff @(posedge clk) begin
    if (rst) begin
      held             <= 1'b0;
      long_fired       <= 1'b0;
      click_pending    <= 1'b0;
      edge_time        <= '0;
      press_start_time <= '0;
      release_time     <= '0;
    end else if (step) begin
      held             <= held_next;
      long_fired       <= long_fired_next;
      click_pending    <= click_pending_next;
      edge_time        <= edge_time_next;
      press_start_time <= press_start_time_next;
      release_time     <= release_time_next;
    end
  end

endmodule

@@ hw/rtl/rotenc_outq.sv @@
`timescale 1ns / 1ps

module rotenc_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push0,
  input  rotenc_pkg::oq_entry_t ent0,
  input  logic                  push1,
  input  rotenc_pkg::oq_entry_t ent1,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            event_code,
  output logic                  last_event
);
  import rotenc_pkg::*;

  oq_entry_t        q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] wr_ptr_1;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic [OQ_CW-1:0] n_push;
  logic             pop;

  assign wr_ptr_1   = wr_ptr + OQ_AW'(1);
  assign n_push     = OQ_CW'(push0) + OQ_CW'(push1);
  assign pop        = out_valid && !out_stall;
  assign out_valid  = (count != '0);
  assign room       = (count <= OQ_CW'(OQ_DEPTH - 2));
  assign event_code = q[rd_ptr].code;
  assign last_event = q[rd_ptr].last;

  // Entry storage; push1 only comes with push0
  always_ff @(posedge clk) begin
    if (push0) q[wr_ptr]   <= ent0;
    if (push1) q[wr_ptr_1] <= ent1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(n_push);
      if (pop) rd_ptr <= rd_ptr + OQ_AW'(1);
      count  <= count + n_push - OQ_CW'(pop);
    end
  end

endmodule

@@ hw/rtl/rotary_encoder_button_gestures.sv @@
`timescale 1ns / 1ps
// Rotary encoder and push-switch gesture decoder.
// Input channel: in_valid/in_stall with chan_a, chan_b, switch_down and the
// millisecond timestamp now_ms. One item is one sample of the pins.
// Output channel: out_valid/out_stall with event_code and last_event. Each
// sample gives zero, one or two results: a rotation (cw/ccw) first, then at
// most one switch gesture (press, double press, long press). last_event
// marks the final result of a sample.
// Configuration: wr_en/wr_index/wr_data, write only while idle.
// An accepted sample is held in the sample register and decoded from it; its
// results are then registered in the queue, which offers the first of them.
// Throughput: one sample per cycle while the queue has room, set by the combinational decode between
// the sample register and a 4-entry result queue. A sample waits in the
// sample register until the queue has room for two results, so a receiver
// that stalls fills the queue and then stalls the sender via in_stall.
// Reset: state returns to channels idle high, switch released, all times 0,
// thresholds 20/600/350 ms, and the queue empties.
module rotary_encoder_button_gestures (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        chan_a,
  input  logic        chan_b,
  input  logic        switch_down,
  input  logic [31:0] now_ms,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic        last_event
);
  import rotenc_pkg::*;

  logic      s_valid;
  logic      s_a;
  logic      s_b;
  logic      s_sw;
  stamp_t    s_now;
  logic      room;
  logic      step;
  logic      load;
  result_t   rot;
  result_t   sw;
  oq_entry_t ent0;
  oq_entry_t ent1;
  logic      push0;
  logic      push1;

  // Sample register handshake
  assign step     = s_valid && room;
  assign in_stall = s_valid && !room;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (load) begin
      s_valid <= 1'b1;
    end else if (step) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_a   <= chan_a;
      s_b   <= chan_b;
      s_sw  <= switch_down;
      s_now <= stamp_t'(now_ms);
    end
  end

  rotenc_quad u_quad (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .chan_a (s_a),
    .chan_b (s_b),
    .rot    (rot)
  );

  rotenc_switch u_switch (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .switch_down (s_sw),
    .now         (s_now),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .sw          (sw)
  );

  // Order results: rotation first, switch gesture last
  always_comb begin
    ent0.code = rot.valid ? rot.code : sw.code;
    ent0.last = !(rot.valid && sw.valid);
    ent1.code = sw.code;
    ent1.last = 1'b1;
    push0     = step && (rot.valid || sw.valid);
    push1     = step && rot.valid && sw.valid;
  end

  rotenc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .ent0       (ent0),
    .push1      (push1),
    .ent1       (ent1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code),
    .last_event (last_event)
  );

endmodule

@@ hw/rtl/rotenc_checker.sv @@
`timescale 1ns / 1ps

module rotenc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_code,
  input logic        last_event
);
  import rotenc_pkg::*;

  // Queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(last_event))
    else $error("stalled result changed");

  // Only defined event codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= 3'(EV_LONG))
    else $error("undefined event code");

  // Only a rotation can be followed by another result of the same sample
  a_not_last_is_rotation: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_event |-> event_code == 3'(EV_CW) || event_code == 3'(EV_CCW))
    else $error("switch gesture not marked last");

endmodule

bind rotary_encoder_button_gestures rotenc_checker u_rotenc_checker (.*);

@@ verif/rotary_encoder_button_gestures_test.sv @@
`timescale 1ns / 1ps

module rotary_encoder_button_gestures_test;
  import rotenc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Index 3 has no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  // Channel pair in clockwise order
  localparam logic [1:0] GRAY_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

  typedef struct {
    event_t code;
    logic   last;
  } expected_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        chan_a = 1'b1;
  logic        chan_b = 1'b1;
  logic        switch_down = 1'b0;
  logic [31:0] now_ms = '0;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [15:0] wr_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_code;
  logic        last_event;

  rotary_encoder_button_gestures dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .chan_a(chan_a),
    .chan_b(chan_b),
    .switch_down(switch_down),
    .now_ms(now_ms),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_code(event_code),
    .last_event(last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int cycle_count = 0;
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  expected_event_t pending_events [$];

  // Decoder state as the block should hold it
  logic [CFG_W-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic [CFG_W-1:0] hold_cfg     = LONG_PRESS_RESET;
  logic [CFG_W-1:0] window_cfg   = DOUBLE_PRESS_RESET;
  logic [1:0] ab_last    = 2'b11;
  int         step_acc   = 0;
  logic       sw_held    = 1'b0;
  stamp_t     edge_at    = '0;
  stamp_t     press_at   = '0;
  stamp_t     release_at = '0;
  logic       long_done  = 1'b0;
  logic       click_wait = 1'b0;

  // Stimulus generator state
  logic [1:0] gen_ab  = 2'b11;
  logic       gen_sw  = 1'b0;
  stamp_t     gen_ms  = '0;
  int         gen_dir = 1;

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Position of a channel pair along the clockwise sequence
  function automatic int gray_pos(input logic [1:0] ab);
    case (ab)
      2'b00: return 0;
      2'b10: return 1;
      2'b11: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic stamp_t elapsed_ms(input stamp_t t_now, input stamp_t t_then);
    return t_now - t_then;
  endfunction

  // Work out the events one accepted sample causes and queue them
  task automatic decode_sample(input logic a, input logic b, input logic sw, input stamp_t t);
    logic [1:0] cur;
    int         dpos;
    event_t     evs [$];
    cur = {a, b};
    if (cur != ab_last) begin
      dpos = (gray_pos(cur) - gray_pos(ab_last)) & 3;
      if (dpos == 1) step_acc++;
      else if (dpos == 3) step_acc--;
      ab_last = cur;
      if (step_acc >= STEPS_PER_DETENT) begin
        step_acc = 0;
        evs.push_back(EV_CW);
      end else if (step_acc <= -STEPS_PER_DETENT) begin
        step_acc = 0;
        evs.push_back(EV_CCW);
      end
    end
    if (sw != sw_held) begin
      // an edge too close to the last one is dropped, and no timers run
      if (elapsed_ms(t, edge_at) >= stamp_t'(debounce_cfg)) begin
        edge_at = t;
        if (sw) begin
          sw_held = 1'b1;
          press_at = t;
          long_done = 1'b0;
        end else begin
          sw_held = 1'b0;
          if (long_done) begin
            click_wait = 1'b0;
          end else if (click_wait && elapsed_ms(t, release_at) < stamp_t'(window_cfg)) begin
            evs.push_back(EV_DOUBLE);
            click_wait = 1'b0;
          end else begin
            click_wait = 1'b1;
            release_at = t;
          end
        end
      end
    end else begin
      if (sw_held && !long_done && elapsed_ms(t, press_at) >= stamp_t'(hold_cfg)) begin
        long_done = 1'b1;
        evs.push_back(EV_LONG);
      end
      if (click_wait && !sw_held && elapsed_ms(t, release_at) >= stamp_t'(window_cfg)) begin
        evs.push_back(EV_PRESS);
        click_wait = 1'b0;
      end
    end
    foreach (evs[i]) pending_events.push_back('{code: evs[i], last: (i == evs.size() - 1)});
  endtask

  // Check every result the receiver takes against the oldest expectation
  always @(posedge clk) begin : check_results
    expected_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected item code=%0d last=%0b", event_code, last_event));
      end else begin
        want = pending_events.pop_front();
        if (event_code !== want.code)
          report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                    event_code, want.code, want.code.name()));
        if (last_event !== want.last)
          report_mismatch($sformatf("last_event %0b, expected %0b", last_event, want.last));
      end
    end
  end

  // Send one sample; starts and ends at a falling edge
  task automatic send_sample(input logic a, input logic b, input logic sw, input stamp_t t);
    while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    chan_a = a;
    chan_b = b;
    switch_down = sw;
    now_ms = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_sample(a, b, sw, t);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  // Drained, plus time for a sample that gives no result to clear the block
  task automatic wait_idle();
    wait_drained();
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE:     debounce_cfg = val;
      CFG_LONG_PRESS:   hold_cfg = val;
      CFG_DOUBLE_PRESS: window_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                                input logic [CFG_W-1:0] window);
    wait_idle();
    write_register(CFG_DEBOUNCE, deb);
    write_register(CFG_LONG_PRESS, hold);
    write_register(CFG_DOUBLE_PRESS, window);
  endtask

  // Time step between samples, often landing near one of the thresholds
  function automatic stamp_t pick_gap();
    logic [CFG_W-1:0] thr;
    case ($urandom_range(0, 5))
      0: return stamp_t'($urandom_range(0, 3));
      1: thr = debounce_cfg;
      2: thr = hold_cfg;
      3: thr = window_cfg;
      4: return stamp_t'($urandom_range(0, 800));
      default: return stamp_t'($urandom_range(0, 70000));
    endcase
    return (thr < 16'd2) ? stamp_t'($urandom_range(0, 4))
                         : stamp_t'(thr) + $urandom_range(0, 4) - 2;
  endfunction

  // Mostly steady turning and clicking, with invalid jumps and time warps as noise
  task automatic random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 99) < 10) gen_dir = 4 - gen_dir;
      gen_ab = GRAY_SEQ[2'((gray_pos(gen_ab) + gen_dir) & 3)];
    end else if (pick < 45) begin
      gen_ab = gen_ab ^ 2'b11;
    end else if (pick < 48) begin
      gen_ab = 2'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 99) < 25) gen_sw = ~gen_sw;
    gen_ms = gen_ms + pick_gap();
    if ($urandom_range(0, 99) < 2) gen_ms = $urandom();
    send_sample(gen_ab[1], gen_ab[0], gen_sw, gen_ms);
  endtask

  // Random phase; halfway through the sender waits until all events are out
  task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      random_sample();
    end
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Reset thresholds: early edge, detents both ways, invalid pair change,
  // debounce, press, double press, long press, both results in one sample, wrap
  task automatic test_directed_gestures();
    send_sample(1, 1, 1, 32'd5);
    send_sample(0, 1, 1, 32'd30);
    send_sample(0, 0, 1, 32'd40);
    send_sample(1, 0, 1, 32'd50);
    send_sample(1, 1, 0, 32'd60);
    send_sample(1, 1, 1, 32'd70);
    send_sample(1, 1, 1, 32'd100);
    send_sample(1, 1, 0, 32'd150);
    send_sample(1, 0, 0, 32'd200);
    send_sample(0, 0, 0, 32'd210);
    send_sample(0, 1, 0, 32'd220);
    send_sample(1, 1, 0, 32'd230);
    send_sample(0, 0, 0, 32'd240);
    send_sample(1, 1, 0, 32'd250);
    send_sample(1, 1, 1, 32'd300);
    send_sample(1, 1, 1, 32'd899);
    send_sample(1, 1, 1, 32'd900);
    send_sample(1, 1, 0, 32'd950);
    send_sample(1, 1, 1, 32'd1000);
    send_sample(1, 1, 0, 32'd1050);
    send_sample(1, 1, 0, 32'd1399);
    send_sample(1, 1, 0, 32'd1400);
    send_sample(0, 1, 1, 32'd2000);
    send_sample(0, 0, 0, 32'd2100);
    send_sample(1, 0, 0, 32'd2110);
    send_sample(1, 1, 0, 32'd2500);
    send_sample(1, 1, 1, 32'hFFFF_FFFF);
    send_sample(1, 1, 0, 32'h0000_001F);
    send_sample(1, 1, 0, 32'h8000_0000);
    gen_ms = 32'h8000_0100;
  endtask

  task automatic test_default_timing();
    run_random_phase(110, 0, 0);
    run_random_phase(110, 76, 0);
    run_random_phase(110, 0, 76);
    run_random_phase(110, 8, 8);
  endtask

  task automatic test_zero_thresholds();
    set_thresholds('0, '0, '0);
    run_random_phase(100, 8, 8);
  endtask

  task automatic test_max_thresholds();
    set_thresholds('1, '1, '1);
    run_random_phase(120, 0, 76);
  endtask

  task automatic test_random_thresholds();
    set_thresholds(CFG_W'($urandom_range(0, 50)), CFG_W'($urandom_range(0, 1000)),
                   CFG_W'($urandom_range(0, 500)));
    run_random_phase(80, 76, 0);
    set_thresholds(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                   CFG_W'($urandom_range(0, 65535)));
    run_random_phase(80, 8, 8);
  endtask

  task automatic test_unused_register();
    set_thresholds(DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_PRESS_RESET);
    write_register(CFG_UNUSED, CFG_W'($urandom_range(0, 65535)));
    run_random_phase(40, 0, 0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed_gestures();
    test_default_timing();
    test_zero_thresholds();
    test_max_thresholds();
    test_random_thresholds();
    test_unused_register();
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
